// ----- design/gcba_pkg.sv -----
// Shared constants for the grid cell bit address unit: axis scales, grid sizes and weights.
`default_nettype none

package gcba_pkg;

	localparam int FRAC_BITS   = 12;
	localparam int COORD_WIDTH = 20;

	localparam int AXES     = 8;
	localparam int FLAT_W   = 33;
	localparam int BYTE_W   = 31;
	localparam int OFFSET_W = 3;

	// Wrist angles 0 .. 50 degrees: the scale 36/pi is held with 24 fraction bits.
	localparam longint WRIST_MUL   = 192252734;
	localparam longint WRIST_BIAS  = 8388608;
	localparam int     WRIST_EXTRA = 24;
	localparam int     WRIST_CELLS = 11;
	localparam int     WRIST_W     = 4;

	// Positions: exact rational scales, bias in units of one coordinate LSB times 2^FRAC_BITS.
	localparam longint X_MUL   = 90;
	localparam longint X_BIAS  = 29;
	localparam int     X_EXTRA = 2;
	localparam int     X_CELLS = 19;
	localparam int     X_W     = 5;

	localparam longint Y_MUL   = 90;
	localparam longint Y_BIAS  = -25;
	localparam int     Y_EXTRA = 2;
	localparam int     Y_CELLS = 10;
	localparam int     Y_W     = 4;

	localparam longint Z_MUL   = 88;
	localparam longint Z_BIAS  = -42;
	localparam int     Z_EXTRA = 2;
	localparam int     Z_CELLS = 12;
	localparam int     Z_W     = 4;

	// Place values of the mixed-radix flat index, left z fastest.
	localparam logic [FLAT_W-1:0] WGT_LZ  = FLAT_W'(1);
	localparam logic [FLAT_W-1:0] WGT_LY  = FLAT_W'(Z_CELLS);
	localparam logic [FLAT_W-1:0] WGT_LX  = FLAT_W'(Z_CELLS * Y_CELLS);
	localparam logic [FLAT_W-1:0] WGT_RZ  = FLAT_W'(Z_CELLS * Y_CELLS * X_CELLS);
	localparam logic [FLAT_W-1:0] WGT_RY  = FLAT_W'(Z_CELLS * Y_CELLS * X_CELLS * Z_CELLS);
	localparam logic [FLAT_W-1:0] WGT_RX  =
		FLAT_W'(Z_CELLS * Y_CELLS * X_CELLS * Z_CELLS * Y_CELLS);
	localparam logic [FLAT_W-1:0] WGT_LW  =
		FLAT_W'(Z_CELLS * Y_CELLS * X_CELLS * Z_CELLS * Y_CELLS * X_CELLS);
	localparam logic [FLAT_W-1:0] WGT_RW  =
		FLAT_W'(Z_CELLS * Y_CELLS * X_CELLS * Z_CELLS * Y_CELLS * X_CELLS * WRIST_CELLS);

endpackage

`default_nettype wire

// ----- design/grid_cell_bit_address_unit.sv -----
// Top level of the grid cell bit address unit: three-stage quantize and flatten pipeline.
//
//  channel | signals                              | direction | word
//  in      | in_valid, in_ready, eight coords     | into unit | one pose sample
//  out     | out_valid, out_ready, cells, address | out of    | cells, flat index, address
//
// out_valid rises once an accepted word has passed the stage one, two and three registers;
// one word per cycle sustained while out_ready stays high.
// Stage one registers the coordinates, stage two holds the eight cells after the
// constant multiplies, stage three holds the flat index after the weighted sum.
// A stall on out_ready holds each full stage; empty stages still fill, so the unit
// holds up to three words while the output waits. Reset clears only the valid bits.
`default_nettype none

module grid_cell_bit_address_unit #(
	parameter int FRAC_BITS   = gcba_pkg::FRAC_BITS,
	parameter int COORD_WIDTH = gcba_pkg::COORD_WIDTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,

	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [COORD_WIDTH-1:0]       right_wrist_angle,
	input  wire logic signed [COORD_WIDTH-1:0]       left_wrist_angle,
	input  wire logic signed [COORD_WIDTH-1:0]       right_x,
	input  wire logic signed [COORD_WIDTH-1:0]       right_y,
	input  wire logic signed [COORD_WIDTH-1:0]       right_z,
	input  wire logic signed [COORD_WIDTH-1:0]       left_x,
	input  wire logic signed [COORD_WIDTH-1:0]       left_y,
	input  wire logic signed [COORD_WIDTH-1:0]       left_z,

	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [gcba_pkg::WRIST_W-1:0]             right_wrist_cell,
	output logic [gcba_pkg::WRIST_W-1:0]             left_wrist_cell,
	output logic [gcba_pkg::X_W-1:0]                 right_x_cell,
	output logic [gcba_pkg::Y_W-1:0]                 right_y_cell,
	output logic [gcba_pkg::Z_W-1:0]                 right_z_cell,
	output logic [gcba_pkg::X_W-1:0]                 left_x_cell,
	output logic [gcba_pkg::Y_W-1:0]                 left_y_cell,
	output logic [gcba_pkg::Z_W-1:0]                 left_z_cell,
	output logic [gcba_pkg::FLAT_W-1:0]              flat_cell_index,
	output logic [gcba_pkg::BYTE_W-1:0]              byte_address,
	output logic [gcba_pkg::OFFSET_W-1:0]            bit_offset
);

	localparam int FW = gcba_pkg::FLAT_W;

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	logic signed [COORD_WIDTH-1:0] rwa_s1, lwa_s1, rx_s1, ry_s1, rz_s1, lx_s1, ly_s1, lz_s1;

	logic [gcba_pkg::WRIST_W-1:0] rwa_c, lwa_c, rwa_s2, lwa_s2, rwa_s3, lwa_s3;
	logic [gcba_pkg::X_W-1:0]     rx_c, lx_c, rx_s2, lx_s2, rx_s3, lx_s3;
	logic [gcba_pkg::Y_W-1:0]     ry_c, ly_c, ry_s2, ly_s2, ry_s3, ly_s3;
	logic [gcba_pkg::Z_W-1:0]     rz_c, lz_c, rz_s2, lz_s2, rz_s3, lz_s3;

	logic [FW-1:0] flat_c, flat_s3;

	// Each stage advances when the one after it is empty or moving.
	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			rwa_s1 <= right_wrist_angle;
			lwa_s1 <= left_wrist_angle;
			rx_s1  <= right_x;
			ry_s1  <= right_y;
			rz_s1  <= right_z;
			lx_s1  <= left_x;
			ly_s1  <= left_y;
			lz_s1  <= left_z;
		end
	end

	gcba_axis_quant #(
		.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH),
		.MUL(gcba_pkg::WRIST_MUL), .BIAS(gcba_pkg::WRIST_BIAS),
		.EXTRA(gcba_pkg::WRIST_EXTRA), .CELLS(gcba_pkg::WRIST_CELLS),
		.CELL_W(gcba_pkg::WRIST_W)
	) u_q_rwa (.coord(rwa_s1), .cell_idx(rwa_c));

	gcba_axis_quant #(
		.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH),
		.MUL(gcba_pkg::WRIST_MUL), .BIAS(gcba_pkg::WRIST_BIAS),
		.EXTRA(gcba_pkg::WRIST_EXTRA), .CELLS(gcba_pkg::WRIST_CELLS),
		.CELL_W(gcba_pkg::WRIST_W)
	) u_q_lwa (.coord(lwa_s1), .cell_idx(lwa_c));

	gcba_axis_quant #(
		.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH),
		.MUL(gcba_pkg::X_MUL), .BIAS(gcba_pkg::X_BIAS), .EXTRA(gcba_pkg::X_EXTRA),
		.CELLS(gcba_pkg::X_CELLS), .CELL_W(gcba_pkg::X_W)
	) u_q_rx (.coord(rx_s1), .cell_idx(rx_c));

	gcba_axis_quant #(
		.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH),
		.MUL(gcba_pkg::Y_MUL), .BIAS(gcba_pkg::Y_BIAS), .EXTRA(gcba_pkg::Y_EXTRA),
		.CELLS(gcba_pkg::Y_CELLS), .CELL_W(gcba_pkg::Y_W)
	) u_q_ry (.coord(ry_s1), .cell_idx(ry_c));

	gcba_axis_quant #(
		.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH),
		.MUL(gcba_pkg::Z_MUL), .BIAS(gcba_pkg::Z_BIAS), .EXTRA(gcba_pkg::Z_EXTRA),
		.CELLS(gcba_pkg::Z_CELLS), .CELL_W(gcba_pkg::Z_W)
	) u_q_rz (.coord(rz_s1), .cell_idx(rz_c));

	gcba_axis_quant #(
		.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH),
		.MUL(gcba_pkg::X_MUL), .BIAS(gcba_pkg::X_BIAS), .EXTRA(gcba_pkg::X_EXTRA),
		.CELLS(gcba_pkg::X_CELLS), .CELL_W(gcba_pkg::X_W)
	) u_q_lx (.coord(lx_s1), .cell_idx(lx_c));

	gcba_axis_quant #(
		.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH),
		.MUL(gcba_pkg::Y_MUL), .BIAS(gcba_pkg::Y_BIAS), .EXTRA(gcba_pkg::Y_EXTRA),
		.CELLS(gcba_pkg::Y_CELLS), .CELL_W(gcba_pkg::Y_W)
	) u_q_ly (.coord(ly_s1), .cell_idx(ly_c));

	gcba_axis_quant #(
		.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH),
		.MUL(gcba_pkg::Z_MUL), .BIAS(gcba_pkg::Z_BIAS), .EXTRA(gcba_pkg::Z_EXTRA),
		.CELLS(gcba_pkg::Z_CELLS), .CELL_W(gcba_pkg::Z_W)
	) u_q_lz (.coord(lz_s1), .cell_idx(lz_c));

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			rwa_s2 <= rwa_c;
			lwa_s2 <= lwa_c;
			rx_s2  <= rx_c;
			ry_s2  <= ry_c;
			rz_s2  <= rz_c;
			lx_s2  <= lx_c;
			ly_s2  <= ly_c;
			lz_s2  <= lz_c;
		end
	end

	// The flat index is a sum of cells times constant place values.
	assign flat_c = FW'(rwa_s2) * gcba_pkg::WGT_RW + FW'(lwa_s2) * gcba_pkg::WGT_LW
		+ FW'(rx_s2) * gcba_pkg::WGT_RX + FW'(ry_s2) * gcba_pkg::WGT_RY
		+ FW'(rz_s2) * gcba_pkg::WGT_RZ + FW'(lx_s2) * gcba_pkg::WGT_LX
		+ FW'(ly_s2) * gcba_pkg::WGT_LY + FW'(lz_s2) * gcba_pkg::WGT_LZ;

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			rwa_s3  <= rwa_s2;
			lwa_s3  <= lwa_s2;
			rx_s3   <= rx_s2;
			ry_s3   <= ry_s2;
			rz_s3   <= rz_s2;
			lx_s3   <= lx_s2;
			ly_s3   <= ly_s2;
			lz_s3   <= lz_s2;
			flat_s3 <= flat_c;
		end
	end

	assign out_valid        = v_s3;
	assign right_wrist_cell = rwa_s3;
	assign left_wrist_cell  = lwa_s3;
	assign right_x_cell     = rx_s3;
	assign right_y_cell     = ry_s3;
	assign right_z_cell     = rz_s3;
	assign left_x_cell      = lx_s3;
	assign left_y_cell      = ly_s3;
	assign left_z_cell      = lz_s3;
	assign flat_cell_index  = flat_s3;
	// Four 2-bit entries share a byte.
	assign byte_address     = flat_s3[FW-1:2];
	assign bit_offset       = {flat_s3[1:0], 1'b0};

endmodule

`default_nettype wire

// ----- design/gcba_axis_quant.sv -----
// Quantizer for one grid axis: scale, bias, round half up and saturate to the cell range.
`default_nettype none

module gcba_axis_quant #(
	parameter int     FRAC_BITS   = gcba_pkg::FRAC_BITS,
	parameter int     COORD_WIDTH = gcba_pkg::COORD_WIDTH,
	parameter longint MUL         = gcba_pkg::X_MUL,
	parameter longint BIAS        = gcba_pkg::X_BIAS,
	parameter int     EXTRA       = gcba_pkg::X_EXTRA,
	parameter int     CELLS       = gcba_pkg::X_CELLS,
	parameter int     CELL_W      = gcba_pkg::X_W
) (
	input  wire logic signed [COORD_WIDTH-1:0] coord,
	output logic             [CELL_W-1:0]      cell_idx
);

	// The scale constant fits in 29 signed bits, so this width never overflows.
	localparam int SUM_W = COORD_WIDTH + 30;
	localparam int SH    = FRAC_BITS + EXTRA;

	localparam logic signed [SUM_W-1:0] MUL_C  = SUM_W'(MUL);
	localparam logic signed [SUM_W-1:0] BIAS_C = SUM_W'(BIAS) <<< FRAC_BITS;
	localparam logic        [SUM_W-1:0] SAT_C  = SUM_W'(CELLS - 1);

	logic signed [SUM_W-1:0] coord_ext;
	logic signed [SUM_W-1:0] sum;
	logic        [SUM_W-1:0] sum_u;
	logic        [SUM_W-1:0] idx;

	always_comb begin
		coord_ext = SUM_W'(coord);
		sum       = coord_ext * MUL_C + BIAS_C;
		sum_u     = sum;
		idx       = sum_u >> SH;
		if (sum[SUM_W-1]) begin
			cell_idx = '0;
		end else if (idx > SAT_C) begin
			cell_idx = CELL_W'(CELLS - 1);
		end else begin
			cell_idx = idx[CELL_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- design/gcba_checker.sv -----
// Port-level checks for the grid cell bit address unit, bound to the top level.
`default_nettype none

module gcba_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic [gcba_pkg::WRIST_W-1:0]        right_wrist_cell,
	input wire logic [gcba_pkg::WRIST_W-1:0]        left_wrist_cell,
	input wire logic [gcba_pkg::X_W-1:0]            right_x_cell,
	input wire logic [gcba_pkg::Y_W-1:0]            right_y_cell,
	input wire logic [gcba_pkg::Z_W-1:0]            right_z_cell,
	input wire logic [gcba_pkg::X_W-1:0]            left_x_cell,
	input wire logic [gcba_pkg::Y_W-1:0]            left_y_cell,
	input wire logic [gcba_pkg::Z_W-1:0]            left_z_cell,
	input wire logic [gcba_pkg::FLAT_W-1:0]         flat_cell_index,
	input wire logic [gcba_pkg::BYTE_W-1:0]         byte_address,
	input wire logic [gcba_pkg::OFFSET_W-1:0]       bit_offset
);

	localparam int FW = gcba_pkg::FLAT_W;

	logic [FW-1:0] flat_exp;

	assign flat_exp = FW'(right_wrist_cell) * gcba_pkg::WGT_RW
		+ FW'(left_wrist_cell) * gcba_pkg::WGT_LW
		+ FW'(right_x_cell) * gcba_pkg::WGT_RX + FW'(right_y_cell) * gcba_pkg::WGT_RY
		+ FW'(right_z_cell) * gcba_pkg::WGT_RZ + FW'(left_x_cell) * gcba_pkg::WGT_LX
		+ FW'(left_y_cell) * gcba_pkg::WGT_LY + FW'(left_z_cell) * gcba_pkg::WGT_LZ;

	// A stalled result word holds; the flat index and the right wrist and left z cells are checked.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(flat_cell_index)
			&& $stable(right_wrist_cell) && $stable(left_z_cell))
		else $error("result word changed while stalled");

	// Every cell sits inside its axis range.
	a_cell_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> right_wrist_cell < 4'd11 && left_wrist_cell < 4'd11
			&& right_x_cell < 5'd19 && left_x_cell < 5'd19
			&& right_y_cell < 4'd10 && left_y_cell < 4'd10
			&& right_z_cell < 4'd12 && left_z_cell < 4'd12)
		else $error("cell index out of range");

	// The flat index is the mixed-radix value of the cells shown with it.
	a_flat_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> flat_cell_index == flat_exp)
		else $error("flat index does not match cells");

	// Byte address and bit offset split the flat index.
	a_addr_split: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_address == flat_cell_index[FW-1:2]
			&& bit_offset[2:1] == flat_cell_index[1:0] && !bit_offset[0])
		else $error("address split does not match flat index");

endmodule

bind grid_cell_bit_address_unit gcba_checker u_gcba_checker (.*);

`default_nettype wire
